// ----- hw/rtl/bba_pkg.sv -----
// Shared constants and block-tree index helpers for the buddy allocator.
`default_nettype none
package bba_pkg;
    localparam int HEAP_BYTES      = 2048;
    localparam int MIN_BLOCK_BYTES = 4;
    localparam int NBLK            = HEAP_BYTES / MIN_BLOCK_BYTES;
    localparam int TOP             = $clog2(NBLK);
    localparam int NNODES          = 2 * NBLK - 1;
    localparam int BLKW            = $clog2(NBLK);
    localparam int NODEW           = $clog2(NNODES);
    localparam int OFFW            = $clog2(MIN_BLOCK_BYTES);
    localparam int LVW             = 4;
    localparam int REQW            = 16;
    localparam int ADDRW           = 11;
    localparam int SIZEW           = 12;

    typedef logic [LVW-1:0]   lvl_t;
    typedef logic [BLKW-1:0]  blk_t;
    typedef logic [NODEW-1:0] node_t;

    // first tree node of a level (nodes of one level are contiguous, by address)
    function automatic node_t lvl_first(lvl_t lev);
        logic [NODEW:0] v;
        v = ((NODEW+1)'(1) << (LVW'(TOP) - lev)) - (NODEW+1)'(1);
        return v[NODEW-1:0];
    endfunction

    function automatic node_t lvl_last(lvl_t lev);
        logic [NODEW:0] v;
        v = ((NODEW+1)'(2) << (LVW'(TOP) - lev)) - (NODEW+1)'(2);
        return v[NODEW-1:0];
    endfunction

    function automatic node_t node_of(lvl_t lev, blk_t blk);
        return lvl_first(lev) + NODEW'(blk >> lev);
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/bba_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/buddy_block_allocator.sv -----
// Buddy allocator top level: request sequencer over the free map and level memories.
//
// Request channel (req_valid/req_ready): kind, request_size, block_start.
// Response channel (rsp_valid/rsp_ready): ok, granted_address, granted_size,
// internal_waste; one response beat per request beat, in order.
// One request is worked on at a time. An allocate walks the free-map memory
// one tree node per cycle, from the first node of the needed level upward,
// then writes one split buddy per level. A free reads the level memory,
// then reads the buddy's free-map bit at each merge level, and marks the
// merged block free when the buddy is taken or the whole heap is reached.
// The free-map read port sets the scan rate.
// After reset a clearing pass writes both memories; req_ready
// stays low until it ends. A finished response sits in the output register;
// req_ready returns once it is loaded, and a new result waits in ST_DONE
// while the receiver stalls.
`default_nettype none
module buddy_block_allocator
    import bba_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire logic             kind,
    input  wire logic [REQW-1:0]  request_size,
    input  wire logic [ADDRW-1:0] block_start,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output logic                  ok,
    output logic      [ADDRW-1:0] granted_address,
    output logic      [SIZEW-1:0] granted_size,
    output logic      [ADDRW-1:0] internal_waste
);
    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_SCAN, ST_SPLIT, ST_AFIN,
        ST_FCHK, ST_FMRG, ST_FMCHK, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    node_t  clr_reg, clr_next;
    logic   kind_reg, kind_next;
    logic [REQW-1:0] req_reg, req_next;
    lvl_t   need_reg, need_next;
    lvl_t   lev_reg, lev_next;
    blk_t   blk_reg, blk_next;
    logic   okw_reg, okw_next;
    node_t  scan_node_reg, scan_node_next;
    lvl_t   scan_lev_reg, scan_lev_next;
    logic   scan_exh_reg, scan_exh_next;
    logic   chk_valid_reg, chk_valid_next;
    node_t  chk_node_reg, chk_node_next;
    lvl_t   chk_lev_reg, chk_lev_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   ok_reg, ok_next;
    logic [ADDRW-1:0] addr_reg, addr_next;
    logic [SIZEW-1:0] size_reg, size_next;
    logic [ADDRW-1:0] waste_reg, waste_next;

    logic  fm_we, fm_wdata, fm_rdata;
    node_t fm_waddr, fm_raddr;
    logic  al_we;
    blk_t  al_waddr, al_raddr;
    lvl_t  al_wdata, al_rdata;

    lvl_t  req_lev;
    logic  req_in_range;
    lvl_t  split_j;
    blk_t  bud;
    logic [NODEW-1:0] found_off;
    logic [SIZEW-1:0] gsize;

    bba_ram #(.WIDTH(1), .DEPTH(NNODES)) u_free_map (
        .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
        .raddr(fm_raddr), .rdata(fm_rdata)
    );

    bba_ram #(.WIDTH(LVW), .DEPTH(NBLK)) u_alloc_level (
        .clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
        .raddr(al_raddr), .rdata(al_rdata)
    );

    // smallest level whose block holds the request
    always_comb
    begin
        logic found;
        found   = 1'b0;
        req_lev = LVW'(TOP);
        for (int l = 0; l <= TOP; l++)
        begin
            if (!found && ((REQW+1)'(MIN_BLOCK_BYTES) << l) >= {1'b0, request_size})
            begin
                found   = 1'b1;
                req_lev = LVW'(l);
            end
        end
    end

    assign req_in_range = (request_size >= REQW'(MIN_BLOCK_BYTES)) &&
                          (request_size <= REQW'(HEAP_BYTES));
    assign split_j   = lev_reg - LVW'(1);
    assign bud       = blk_reg ^ BLKW'(1 << lev_reg);
    assign found_off = (chk_node_reg - lvl_first(chk_lev_reg)) << chk_lev_reg;
    assign gsize     = SIZEW'(MIN_BLOCK_BYTES) << lev_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        kind_next      = kind_reg;
        req_next       = req_reg;
        need_next      = need_reg;
        lev_next       = lev_reg;
        blk_next       = blk_reg;
        okw_next       = okw_reg;
        scan_node_next = scan_node_reg;
        scan_lev_next  = scan_lev_reg;
        scan_exh_next  = scan_exh_reg;
        chk_valid_next = chk_valid_reg;
        chk_node_next  = chk_node_reg;
        chk_lev_next   = chk_lev_reg;
        rsp_valid_next = rsp_valid_reg;
        ok_next        = ok_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        waste_next     = waste_reg;
        fm_we          = 1'b0;
        fm_waddr       = scan_node_reg;
        fm_wdata       = 1'b0;
        fm_raddr       = scan_node_reg;
        al_we          = 1'b0;
        al_waddr       = blk_reg;
        al_wdata       = '0;
        al_raddr       = block_start[ADDRW-1:OFFW];

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                fm_we    = 1'b1;
                fm_waddr = clr_reg;
                fm_wdata = (clr_reg == '0);
                al_we    = ({1'b0, clr_reg} < (NODEW+1)'(NBLK));
                al_waddr = clr_reg[BLKW-1:0];
                if (clr_reg == NODEW'(NNODES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + NODEW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = kind;
                    req_next  = request_size;
                    blk_next  = block_start[ADDRW-1:OFFW];
                    okw_next  = 1'b0;
                    if (!kind)
                    begin
                        if (req_in_range)
                        begin
                            need_next      = req_lev;
                            scan_node_next = lvl_first(req_lev);
                            scan_lev_next  = req_lev;
                            scan_exh_next  = 1'b0;
                            chk_valid_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else if (block_start[OFFW-1:0] == '0)
                    begin
                        state_next = ST_FCHK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                chk_valid_next = !scan_exh_reg;
                chk_node_next  = scan_node_reg;
                chk_lev_next   = scan_lev_reg;
                if (scan_node_reg == lvl_last(scan_lev_reg))
                begin
                    if (scan_lev_reg == LVW'(TOP))
                    begin
                        scan_exh_next = 1'b1;
                    end
                    else
                    begin
                        scan_lev_next  = scan_lev_reg + LVW'(1);
                        scan_node_next = lvl_first(scan_lev_reg + LVW'(1));
                    end
                end
                else
                begin
                    scan_node_next = scan_node_reg + NODEW'(1);
                end
                if (chk_valid_reg && fm_rdata)
                begin
                    fm_we      = 1'b1;
                    fm_waddr   = chk_node_reg;
                    fm_wdata   = 1'b0;
                    blk_next   = found_off[BLKW-1:0];
                    lev_next   = chk_lev_reg;
                    state_next = (chk_lev_reg == need_reg) ? ST_AFIN : ST_SPLIT;
                end
                else if (scan_exh_reg && !chk_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SPLIT:
            begin
                fm_we    = 1'b1;
                fm_waddr = node_of(split_j, blk_reg + BLKW'(1 << split_j));
                fm_wdata = 1'b1;
                lev_next = split_j;
                if (split_j == need_reg)
                begin
                    state_next = ST_AFIN;
                end
            end
            ST_AFIN:
            begin
                al_we      = 1'b1;
                al_wdata   = need_reg + LVW'(1);
                okw_next   = 1'b1;
                state_next = ST_DONE;
            end
            ST_FCHK:
            begin
                if (al_rdata != '0 && al_rdata <= LVW'(TOP + 1))
                begin
                    al_we      = 1'b1;
                    al_wdata   = '0;
                    okw_next   = 1'b1;
                    lev_next   = al_rdata - LVW'(1);
                    state_next = ST_FMRG;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FMRG:
            begin
                if (lev_reg < LVW'(TOP))
                begin
                    fm_raddr   = node_of(lev_reg, bud);
                    state_next = ST_FMCHK;
                end
                else
                begin
                    fm_we      = 1'b1;
                    fm_waddr   = node_of(lev_reg, blk_reg);
                    fm_wdata   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_FMCHK:
            begin
                if (fm_rdata)
                begin
                    fm_we      = 1'b1;
                    fm_waddr   = node_of(lev_reg, bud);
                    fm_wdata   = 1'b0;
                    blk_next   = blk_reg & ~BLKW'(1 << lev_reg);
                    lev_next   = lev_reg + LVW'(1);
                    state_next = ST_FMRG;
                end
                else
                begin
                    fm_we      = 1'b1;
                    fm_waddr   = node_of(lev_reg, blk_reg);
                    fm_wdata   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    ok_next        = okw_reg;
                    if (okw_reg && !kind_reg)
                    begin
                        addr_next  = {blk_reg, {OFFW{1'b0}}};
                        size_next  = gsize;
                        waste_next = ADDRW'(gsize - req_reg[SIZEW-1:0]);
                    end
                    else
                    begin
                        addr_next  = '0;
                        size_next  = '0;
                        waste_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            kind_reg      <= 1'b0;
            req_reg       <= '0;
            need_reg      <= '0;
            lev_reg       <= '0;
            blk_reg       <= '0;
            okw_reg       <= 1'b0;
            scan_node_reg <= '0;
            scan_lev_reg  <= '0;
            scan_exh_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            chk_node_reg  <= '0;
            chk_lev_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            addr_reg      <= '0;
            size_reg      <= '0;
            waste_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            kind_reg      <= kind_next;
            req_reg       <= req_next;
            need_reg      <= need_next;
            lev_reg       <= lev_next;
            blk_reg       <= blk_next;
            okw_reg       <= okw_next;
            scan_node_reg <= scan_node_next;
            scan_lev_reg  <= scan_lev_next;
            scan_exh_reg  <= scan_exh_next;
            chk_valid_reg <= chk_valid_next;
            chk_node_reg  <= chk_node_next;
            chk_lev_reg   <= chk_lev_next;
            rsp_valid_reg <= rsp_valid_next;
            ok_reg        <= ok_next;
            addr_reg      <= addr_next;
            size_reg      <= size_next;
            waste_reg     <= waste_next;
        end
    end

    assign req_ready       = (state_reg == ST_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign ok              = ok_reg;
    assign granted_address = addr_reg;
    assign granted_size    = size_reg;
    assign internal_waste  = waste_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/bba_checker.sv -----
// Port-level checks for the buddy allocator, bound to the top level.
`default_nettype none
module bba_checker
    import bba_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic             ok,
    input wire logic [ADDRW-1:0] granted_address,
    input wire logic [SIZEW-1:0] granted_size,
    input wire logic [ADDRW-1:0] internal_waste
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_address) && $stable(ok))
        else $error("response beat dropped or changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> granted_address == '0 && granted_size == '0 &&
        internal_waste == '0)
        else $error("failed response carries nonzero fields");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && granted_size != '0 |->
        $onehot(granted_size) &&
        ((SIZEW'(granted_address) & (granted_size - SIZEW'(1))) == '0))
        else $error("granted block not a power of two or not aligned");

    a_waste: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && granted_size != '0 |-> SIZEW'(internal_waste) < granted_size)
        else $error("waste not below granted size");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk(clk), .rst_n(rst_n), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .ok(ok), .granted_address(granted_address), .granted_size(granted_size),
    .internal_waste(internal_waste)
);
`default_nettype wire
